@@ hw/rtl/pdmr_pkg.sv @@
// Package for the packet deframer memory request block.
// Holds buffer sizes, tag codes, the parser phase type and the queue entry type.
// No dependencies.
package pdmr_pkg;

   localparam int BUF_BITS  = 128;
   localparam int BYTE_BITS = 8;

   localparam int CNT_W       = 8;
   localparam int DATA_BITS   = 7;
   localparam int WR_BYTES    = 9;
   localparam int RD_BYTES    = 5;
   localparam int PAYLOAD_W   = WR_BYTES * BYTE_BITS;
   localparam int WORD_W      = 32;
   localparam int MASK_W      = 4;
   localparam int ID_W        = 5;
   localparam int TAG_W       = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [TAG_W-1:0] TAG_START   = 3'b100;
   localparam logic [TAG_W-1:0] TAG_CHANNEL = 3'b101;
   localparam logic [TAG_W-1:0] TAG_LENGTH  = 3'b110;
   localparam logic [TAG_W-1:0] TAG_END     = 3'b111;

   localparam logic [ID_W-1:0] LEN_READ  = ID_W'(RD_BYTES);
   localparam logic [ID_W-1:0] LEN_WRITE = ID_W'(WR_BYTES);

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_CHANNEL = 5'b00010,
      PH_LENGTH  = 5'b00100,
      PH_DATA    = 5'b01000,
      PH_END     = 5'b10000
   } phase_type;

   typedef struct packed {
      logic                 is_write;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

endpackage

@@ hw/rtl/pdmr_ifs.sv @@
// Channel interfaces for the packet deframer memory request block.
// Request channel carries one received byte a beat; response channel one memory request.
// No dependencies.
interface pdmr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pdmr_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_write;
   logic [31:0] address;
   logic [31:0] write_data;
   logic [3:0]  byte_mask;
   modport source (output valid, output is_write, output address, output write_data,
                   output byte_mask, input ready);
   modport sink   (input valid, input is_write, input address, input write_data,
                   input byte_mask, output ready);
endinterface

@@ hw/rtl/pdmr_front.sv @@
// Front end: accepts received bytes, tracks the frame phase and packs data bits.
// Pushes a classified request into the queue on a matching end byte.
// Depends on pdmr_pkg and pdmr_req_if.
module pdmr_front import pdmr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   pdmr_req_if.sink         req_chan,
   output logic             push_valid,
   output entry_type        push_entry,
   input  logic             push_ready
);

   phase_type            phase_ff, phase_in;
   logic [ID_W-1:0]      tag_ff, tag_in;
   logic [ID_W-1:0]      exp_ff, exp_in;
   logic [CNT_W-1:0]     bits_ff, bits_in;
   logic [BUF_BITS-1:0]  buf_ff, buf_in;

   logic                 accept;
   logic [TAG_W-1:0]     tag;
   logic [ID_W-1:0]      low5;
   logic [CNT_W:0]       total;
   logic [CNT_W:0]       off;
   logic                 id_match;
   logic                 is_read;
   logic                 is_wr;

   assign req_chan.ready = push_ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign tag    = req_chan.rx_byte[7:5];
   assign low5   = req_chan.rx_byte[ID_W-1:0];
   assign id_match = (tag == TAG_END) && (low5 == tag_ff);
   assign is_read  = (exp_ff == LEN_READ) && (buf_ff[4*BYTE_BITS +: BYTE_BITS] == '0);
   assign is_wr    = (exp_ff == LEN_WRITE);

   assign push_valid          = accept && (phase_ff == PH_END) && id_match && (is_read || is_wr);
   assign push_entry.is_write = is_wr;
   assign push_entry.payload  = buf_ff[PAYLOAD_W-1:0];

   always_comb begin
      phase_in = phase_ff;
      tag_in   = tag_ff;
      exp_in   = exp_ff;
      bits_in  = bits_ff;
      buf_in   = buf_ff;
      total    = {1'b0, bits_ff} + (CNT_W+1)'(DATA_BITS);
      off      = '0;
      if (accept) begin
         case (phase_ff)
            PH_CHANNEL: begin
               phase_in = (tag == TAG_CHANNEL) ? PH_LENGTH : PH_IDLE;
            end
            PH_LENGTH: begin
               if (tag == TAG_LENGTH) begin
                  exp_in   = low5;
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_DATA: begin
               if (!req_chan.rx_byte[7]) begin
                  for (int j = 0; j < BUF_BITS; j++) begin
                     off = (CNT_W+1)'(j) - {1'b0, bits_ff};
                     if (off < (CNT_W+1)'(DATA_BITS)) begin
                        buf_in[j] = req_chan.rx_byte[off[2:0]];
                     end
                  end
                  if (total[CNT_W]) begin
                     bits_in = '1;
                  end else begin
                     bits_in = total[CNT_W-1:0];
                  end
                  if (total >= {1'b0, exp_ff, 3'b000}) begin
                     phase_in = PH_END;
                  end
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_END: begin
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
               if (tag == TAG_START) begin
                  tag_in   = low5;
                  bits_in  = '0;
                  exp_in   = '0;
                  phase_in = PH_CHANNEL;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tag_ff   <= '0;
         exp_ff   <= '0;
         bits_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         tag_ff   <= tag_in;
         exp_ff   <= exp_in;
         bits_ff  <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

@@ hw/rtl/pdmr_queue.sv @@
// Two-entry queue between the front end and the back end.
// Depends on pdmr_pkg.
module pdmr_queue import pdmr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  entry_type push_entry,
   output logic      push_ready,
   output logic      pop_valid,
   output entry_type pop_entry,
   input  logic      pop_ready
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]      count_ff, count_in;
   logic                push;
   logic                pop;

   assign push_ready = (count_ff != (PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/pdmr_back.sv @@
// Back end: turns a queued request into address, data and mask in the output register.
// Depends on pdmr_pkg and pdmr_rsp_if.
module pdmr_back import pdmr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   input  entry_type pop_entry,
   output logic      pop_ready,
   pdmr_rsp_if.source rsp_chan
);

   logic               valid_ff, valid_in;
   logic               wr_ff, wr_in;
   logic [WORD_W-1:0]  addr_ff, addr_in;
   logic [WORD_W-1:0]  data_ff, data_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic               load;

   assign pop_ready = !valid_ff || rsp_chan.ready;
   assign load      = pop_valid && pop_ready;

   always_comb begin
      valid_in = valid_ff;
      if (pop_ready) begin
         valid_in = pop_valid;
      end
      wr_in = pop_entry.is_write;
      if (pop_entry.is_write) begin
         addr_in = pop_entry.payload[WORD_W +: WORD_W];
         data_in = pop_entry.payload[0 +: WORD_W];
         mask_in = pop_entry.payload[2*WORD_W +: MASK_W];
      end else begin
         addr_in = pop_entry.payload[0 +: WORD_W];
         data_in = '0;
         mask_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         wr_ff   <= wr_in;
         addr_ff <= addr_in;
         data_ff <= data_in;
         mask_ff <= mask_in;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.is_write   = wr_ff;
   assign rsp_chan.address    = addr_ff;
   assign rsp_chan.write_data = data_ff;
   assign rsp_chan.byte_mask  = mask_ff;

endmodule

@@ hw/rtl/packet_deframer_memory_request_top.sv @@
// Top level of the packet deframer memory request block.
// Depends on pdmr_pkg, pdmr_ifs, pdmr_front, pdmr_queue and pdmr_back.
//
//   channel    dir  beat                         payload
//   req_chan   in   one received byte            rx_byte[7:0]
//   rsp_chan   out  one read or write request    is_write, address, write_data, byte_mask
//
// One byte a cycle is taken while the two-entry queue has room; the frame parser
// updates its phase and bit buffer in that same cycle.
// A request passes from its end byte through the queue, then the output register, to rsp_chan.
// Synchronous reset returns the parser to idle and empties queue and output register.
// A stalled rsp_chan fills the output register, then the queue, then drops req_chan.ready.
module packet_deframer_memory_request_top import pdmr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pdmr_req_if.sink   req_chan,
   pdmr_rsp_if.source rsp_chan
);

   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   pdmr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   pdmr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   pdmr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ dv/tb_packet_deframer_memory_request_top.sv @@
`timescale 1ns / 100ps
// Testbench for packet_deframer_memory_request_top: random and directed byte frames.
// A scoreboard class predicts read and write requests; depends on pdmr_pkg, pdmr_ifs and the RTL.
module tb_packet_deframer_memory_request_top;
   import pdmr_pkg::*;

   localparam int RANDOM_BYTES = 900;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_GAP      = 10;
   localparam int REPORT_CAP   = 200;

   typedef struct packed {
      logic              is_write;
      logic [WORD_W-1:0] address;
      logic [WORD_W-1:0] write_data;
      logic [MASK_W-1:0] byte_mask;
   } mem_request_type;

   typedef enum int {FLAW_NONE, FLAW_BAD_BEAT, FLAW_END_ID, FLAW_END_TAG} frame_flaw_type;

   class request_scoreboard;
      phase_type            phase;
      logic [ID_W-1:0]      packet_id;
      logic [ID_W-1:0]      expected_bytes;
      logic [CNT_W-1:0]     bits_received;
      logic [BUF_BITS-1:0]  payload_bits;
      mem_request_type      pending_q[$];
      int                   failures;

      function new();
         phase          = PH_IDLE;
         packet_id      = '0;
         expected_bytes = '0;
         bits_received  = '0;
         payload_bits   = '0;
         failures       = 0;
      endfunction

      function void note_byte(logic [7:0] rx);
         logic [TAG_W-1:0] tag;
         logic [ID_W-1:0]  low5;
         int               pos;
         int               total;
         mem_request_type  req;
         tag  = rx[7:5];
         low5 = rx[4:0];
         case (phase)
            PH_CHANNEL: phase = (tag == TAG_CHANNEL) ? PH_LENGTH : PH_IDLE;
            PH_LENGTH: begin
               if (tag == TAG_LENGTH) begin
                  expected_bytes = low5;
                  phase = PH_DATA;
               end else begin
                  phase = PH_IDLE;
               end
            end
            PH_DATA: begin
               if (!rx[7]) begin
                  for (int i = 0; i < DATA_BITS; i++) begin
                     pos = int'(bits_received) + i;
                     if (pos < BUF_BITS) payload_bits[pos] = rx[i];
                  end
                  total = int'(bits_received) + DATA_BITS;
                  if (total > 255) total = 255;
                  bits_received = CNT_W'(total);
                  if (total >= int'(expected_bytes) * BYTE_BITS) phase = PH_END;
               end else begin
                  phase = PH_IDLE;
               end
            end
            PH_END: begin
               if (tag == TAG_END && low5 == packet_id) begin
                  if (expected_bytes == LEN_READ && payload_bits[39:32] == 8'h00) begin
                     req = {1'b0, payload_bits[31:0], 32'h0, 4'h0};
                     pending_q.insert(pending_q.size(), req);
                  end else if (expected_bytes == LEN_WRITE) begin
                     req = {1'b1, payload_bits[63:32], payload_bits[31:0], payload_bits[67:64]};
                     pending_q.insert(pending_q.size(), req);
                  end
               end
               phase = PH_IDLE;
            end
            default: begin
               phase = PH_IDLE;
               if (tag == TAG_START) begin
                  packet_id      = low5;
                  bits_received  = '0;
                  expected_bytes = '0;
                  phase          = PH_CHANNEL;
               end
            end
         endcase
      endfunction

      function void report(string field, logic [31:0] exp_val, logic [31:0] act_val);
         failures++;
         if (failures <= REPORT_CAP)
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, exp_val, act_val);
      endfunction

      function void check_request(mem_request_type got);
         mem_request_type want;
         if (pending_q.size() == 0) begin
            failures++;
            if (failures <= REPORT_CAP)
               $error("unexpected request: is_write %0b address 0x%0h", got.is_write, got.address);
            return;
         end
         want = pending_q.pop_front();
         if (got.is_write !== want.is_write) report("is_write", want.is_write, got.is_write);
         if (got.address !== want.address) report("address", want.address, got.address);
         if (got.write_data !== want.write_data)
            report("write_data", want.write_data, got.write_data);
         if (got.byte_mask !== want.byte_mask) report("byte_mask", want.byte_mask, got.byte_mask);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   pdmr_req_if req_chan();
   pdmr_rsp_if rsp_chan();

   packet_deframer_memory_request_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   request_scoreboard sb = new();
   int  frame_bytes = 0;
   int  idle_cycles = 0;
   bit  req_burst   = 1'b0;
   bit  rsp_burst   = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_byte(input logic [7:0] rx);
      int gap;
      if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= rx;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      sb.note_byte(rx);
   endtask

   task automatic send_frame(input logic [ID_W-1:0] len, input logic [255:0] body,
                             input frame_flaw_type flaw);
      logic [7:0]      beats[$];
      logic [ID_W-1:0] id;
      int              n_data;
      int              p;
      id = ID_W'($urandom_range(0, 31));
      n_data = (len == 0) ? 1 : (int'(len) * BYTE_BITS + DATA_BITS - 1) / DATA_BITS;
      beats.insert(beats.size(), {TAG_START, id});
      beats.insert(beats.size(), {TAG_CHANNEL, ID_W'($urandom_range(0, 31))});
      beats.insert(beats.size(), {TAG_LENGTH, len});
      for (int k = 0; k < n_data; k++)
         beats.insert(beats.size(), {1'b0, body[k*DATA_BITS +: DATA_BITS]});
      case (flaw)
         FLAW_END_ID:  beats.insert(beats.size(), {TAG_END, id ^ ID_W'($urandom_range(1, 31))});
         FLAW_END_TAG: beats.insert(beats.size(), {TAG_W'($urandom_range(0, 6)), id});
         default:      beats.insert(beats.size(), {TAG_END, id});
      endcase
      if (flaw == FLAW_BAD_BEAT) begin
         p = $urandom_range(1, beats.size() - 1);
         beats[p] = 8'($urandom_range(128, 255));
      end
      foreach (beats[i]) send_byte(beats[i]);
      frame_bytes += beats.size();
   endtask

   initial begin
      int              stall;
      mem_request_type got;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         got = {rsp_chan.is_write, rsp_chan.address, rsp_chan.write_data, rsp_chan.byte_mask};
         sb.check_request(got);
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      logic [255:0]    body;
      logic [ID_W-1:0] len;
      frame_flaw_type  flaw;
      int              pick;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // idle noise, then read and write frames at field extremes
      send_byte(8'hFF);
      send_byte(8'h00);
      body = '0;
      body[31:0] = 32'hFFFF_FFFF;
      send_frame(LEN_READ, body, FLAW_NONE);
      body = '0;
      body[63:32] = 32'hFFFF_FFFF;
      body[71:64] = 8'hFF;
      send_frame(LEN_WRITE, body, FLAW_NONE);
      body = '0;
      body[31:0]  = 32'hFFFF_FFFF;
      body[71:64] = 8'hF0;
      send_frame(LEN_WRITE, body, FLAW_NONE);
      // zero length, end with wrong id, read whose fifth byte is set
      send_frame(5'd0, '0, FLAW_NONE);
      send_frame(LEN_READ, '0, FLAW_END_ID);
      body = '0;
      body[39:32] = 8'h80;
      send_frame(LEN_READ, body, FLAW_NONE);
      frame_bytes = 0;

      while (frame_bytes < RANDOM_BYTES) begin
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               pick = $urandom_range(0, 255);
               if (pick[7:5] == TAG_START) pick[5] = 1'b1;
               send_byte(8'(pick));
            end
         end
         for (int w = 0; w < 8; w++) body[w*32 +: 32] = $urandom();
         pick = $urandom_range(0, 99);
         if (pick < 40) len = LEN_READ;
         else if (pick < 80) len = LEN_WRITE;
         else if (pick < 85) len = 5'd31;
         else len = ID_W'($urandom_range(0, 31));
         if (len == LEN_READ && $urandom_range(0, 3) != 0) body[39:32] = 8'h00;
         pick = $urandom_range(0, 99);
         if (pick < 80) flaw = FLAW_NONE;
         else if (pick < 88) flaw = FLAW_BAD_BEAT;
         else if (pick < 94) flaw = FLAW_END_ID;
         else flaw = FLAW_END_TAG;
         send_frame(len, body, flaw);
      end
      req_chan.valid <= 1'b0;

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending_q.size() != 0) begin
         sb.failures++;
         $error("%0d requests never arrived", sb.pending_q.size());
      end
      if (sb.failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
